@@ hdl/gspf_pkg.sv @@
package gspf_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_DS_TO_SS_PERIOD = 3'd0;
  localparam logic [2:0] CFG_DS_PERIOD       = 3'd1;
  localparam logic [2:0] CFG_STEP_PERIOD     = 3'd2;
  localparam logic [2:0] CFG_STEPS_BEFORE_DS = 3'd3;
  localparam logic [2:0] CFG_VEL_THRESHOLD   = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register reset values
  localparam logic [15:0] RST_DS_TO_SS_PERIOD = 16'd100;
  localparam logic [15:0] RST_DS_PERIOD       = 16'd1000;
  localparam logic [15:0] RST_STEP_PERIOD     = 16'd800;
  localparam logic [7:0]  RST_STEPS_BEFORE_DS = 8'd2;
  localparam logic [14:0] RST_VEL_THRESHOLD   = 15'd1;

  // Phase and foot codes
  localparam logic PH_DS     = 1'b0;
  localparam logic PH_SS     = 1'b1;
  localparam logic FOOT_LEFT = 1'b0;

  // Sample index that marks the flying foot as still in the air
  localparam logic [5:0] SIDX_FLYING = 6'd1;

  localparam logic [15:0] INSTANTS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [31:0]        now_time;
    logic [5:0]         sample_index;
    logic [15:0]        sample_period;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_yaw;
  } in_t;

  typedef struct packed {
    logic        support_phase;
    logic        support_foot;
    logic        phase_changed;
    logic [31:0] phase_deadline;
    logic [7:0]  steps_remaining;
    logic [15:0] step_count;
    logic [15:0] instant_count;
  } out_t;

  typedef struct packed {
    logic [15:0] ds_to_ss_period;
    logic [15:0] ds_period;
    logic [15:0] step_period;
    logic [7:0]  steps_before_ds;
    logic [14:0] vel_threshold;
  } cfg_t;

  // Sequencer state other than the deadline, whose width is a parameter
  typedef struct packed {
    logic        phase;
    logic        foot;
    logic [7:0]  steps_left;
    logic [15:0] step_number;
    logic [15:0] instants;
  } ctrl_t;

  // Magnitude of a signed 16-bit velocity; the most negative value gives 32768
  function automatic logic [16:0] vel_mag(input logic signed [15:0] v);
    logic [16:0] e;
    e = {v[15], v};
    return v[15] ? (~e + 17'd1) : e;
  endfunction

endpackage

@@ hdl/gait_support_phase_fsm.sv @@
// Support-phase sequencer for a walking gait. Each input word is one sampling
// instant (time, sample period, sample index, velocity command); each produces
// exactly one output word with the support phase, support foot, phase deadline,
// steps left, step number and instants since the last change. One word is
// accepted every clock cycle unless out_ready stalls the output; a word passes
// through the input register, then the output register, and its whole state
// update is done between them. Configuration registers are written through
// cfg_we/cfg_index/cfg_data and should only be changed while no word is in flight.
// TIME_WIDTH sets the width of the internal time base; sums saturate at its top.
module gait_support_phase_fsm #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  gspf_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output gspf_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [gspf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gspf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gspf_pkg::*;

  cfg_t                  cfg;
  logic                  s0_valid;
  in_t                   s0_data;
  logic                  out_free;
  logic                  step_fire;
  ctrl_t                 ctrl;
  ctrl_t                 ctrl_next;
  logic [TIME_WIDTH-1:0] deadline;
  logic [TIME_WIDTH-1:0] deadline_next;
  logic                  changed;

  gspf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gspf_next #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_next (
    .cfg           (cfg),
    .in_word       (s0_data),
    .ctrl          (ctrl),
    .deadline      (deadline),
    .ctrl_next     (ctrl_next),
    .deadline_next (deadline_next),
    .changed       (changed)
  );

  // Handshake: a word advances when the output register is empty or draining
  assign out_free  = !out_valid || out_ready;
  assign step_fire = s0_valid && out_free;
  assign in_ready  = !s0_valid || step_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_data <= in_data;
    end
  end

  // Sequencer state, updated once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase       <= PH_DS;
      ctrl.foot        <= FOOT_LEFT;
      ctrl.steps_left  <= 8'd0;
      ctrl.step_number <= 16'd0;
      ctrl.instants    <= 16'd0;
      deadline         <= '0;
    end else if (step_fire) begin
      ctrl     <= ctrl_next;
      deadline <= deadline_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_data.support_phase   <= ctrl_next.phase;
      out_data.support_foot    <= ctrl_next.foot;
      out_data.phase_changed   <= changed;
      out_data.phase_deadline  <= 32'(deadline_next);
      out_data.steps_remaining <= ctrl_next.steps_left;
      out_data.step_count      <= ctrl_next.step_number;
      out_data.instant_count   <= ctrl_next.instants;
    end
  end

  // A change of state restarts the instant count
  a_change_clears_instants: assert property (@(posedge clk) disable iff (rst)
    step_fire && changed |=> ctrl.instants == 16'd0)
    else $error("instant count not cleared on state change");

  // Without a change, phase and foot hold
  a_no_change_holds_phase: assert property (@(posedge clk) disable iff (rst)
    step_fire && !changed |=> ctrl.phase == $past(ctrl.phase) &&
                              ctrl.foot == $past(ctrl.foot))
    else $error("phase or foot moved without a state change");

  // State moves only when a word is processed
  a_state_only_on_fire: assert property (@(posedge clk) disable iff (rst)
    !step_fire |=> $stable(deadline) && $stable(ctrl))
    else $error("state changed with no word processed");

  // A held word in the input register is not dropped
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    s0_valid && !step_fire |=> s0_valid && $stable(s0_data))
    else $error("input register lost a word");

endmodule

@@ hdl/gspf_cfg.sv @@
module gspf_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [gspf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gspf_pkg::CFG_DATA_W-1:0]    cfg_data,
  output gspf_pkg::cfg_t                     cfg
);
  import gspf_pkg::*;

  // Load reset values, then take writes by index; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ds_to_ss_period <= RST_DS_TO_SS_PERIOD;
      cfg.ds_period       <= RST_DS_PERIOD;
      cfg.step_period     <= RST_STEP_PERIOD;
      cfg.steps_before_ds <= RST_STEPS_BEFORE_DS;
      cfg.vel_threshold   <= RST_VEL_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DS_TO_SS_PERIOD: cfg.ds_to_ss_period <= cfg_data;
        CFG_DS_PERIOD:       cfg.ds_period       <= cfg_data;
        CFG_STEP_PERIOD:     cfg.step_period     <= cfg_data;
        CFG_STEPS_BEFORE_DS: cfg.steps_before_ds <= cfg_data[7:0];
        CFG_VEL_THRESHOLD:   cfg.vel_threshold   <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/gspf_next.sv @@
module gspf_next #(
  parameter int TIME_WIDTH = 32
) (
  input  gspf_pkg::cfg_t          cfg,
  input  gspf_pkg::in_t           in_word,
  input  gspf_pkg::ctrl_t         ctrl,
  input  logic [TIME_WIDTH-1:0]   deadline,
  output gspf_pkg::ctrl_t         ctrl_next,
  output logic [TIME_WIDTH-1:0]   deadline_next,
  output logic                    changed
);
  import gspf_pkg::*;

  // Two guard bits hold a sum of up to three terms
  localparam int SW = TIME_WIDTH + 2;

  function automatic logic [TIME_WIDTH-1:0] sat(input logic [SW-1:0] s);
    return (|s[SW-1:TIME_WIDTH]) ? {TIME_WIDTH{1'b1}} : s[TIME_WIDTH-1:0];
  endfunction

  logic [TIME_WIDTH-1:0] now;
  logic [SW-1:0]         now_w;
  logic [SW-1:0]         sum_ext;
  logic [SW-1:0]         sum_base;
  logic [SW-1:0]         sum_ds;
  logic [SW-1:0]         sum_step;
  logic                  ref_given;
  logic                  ext;
  logic [TIME_WIDTH-1:0] dl1;
  logic [7:0]            sl1;
  logic                  due;
  logic                  sl_zero;

  // Reduce the time stamp to the time width and form all sums in parallel
  always_comb begin
    now      = TIME_WIDTH'(in_word.now_time);
    now_w    = SW'(now);
    sum_ext  = now_w + SW'(cfg.ds_to_ss_period);
    sum_base = now_w + SW'(in_word.sample_period);
    sum_ds   = sum_base + SW'(cfg.ds_period);
    sum_step = sum_base + SW'(cfg.step_period);
  end

  // Velocity reference: any component strictly above the threshold
  assign ref_given = (vel_mag(in_word.vel_x)   > 17'(cfg.vel_threshold)) ||
                     (vel_mag(in_word.vel_y)   > 17'(cfg.vel_threshold)) ||
                     (vel_mag(in_word.vel_yaw) > 17'(cfg.vel_threshold));

  // Pull the double support deadline in when a reference appears
  always_comb begin
    ext     = ref_given && (ctrl.phase == PH_DS) && (SW'(deadline) >= sum_ext);
    dl1     = ext ? sat(sum_ext) : deadline;
    sl1     = ext ? cfg.steps_before_ds : ctrl.steps_left;
    due     = SW'(dl1) <= sum_base;
    sl_zero = (sl1 == 8'd0);
  end

  // Count instants and apply the phase transition rules once the phase is due
  always_comb begin
    ctrl_next            = ctrl;
    ctrl_next.steps_left = sl1;
    deadline_next        = dl1;
    changed              = 1'b0;
    if (ctrl.instants != INSTANTS_MAX) begin
      ctrl_next.instants = ctrl.instants + 16'd1;
    end
    if (due) begin
      if ((ctrl.phase == PH_SS) && !ref_given && sl_zero) begin
        ctrl_next.phase = PH_DS;
        deadline_next   = sat(sum_ds);
        changed         = 1'b1;
      end else if ((ctrl.phase == PH_DS) && (ref_given || !sl_zero)) begin
        ctrl_next.phase      = PH_SS;
        deadline_next        = sat(sum_step);
        ctrl_next.steps_left = cfg.steps_before_ds;
        changed              = 1'b1;
      end else if (((ctrl.phase == PH_SS) && !sl_zero) || (sl_zero && ref_given)) begin
        ctrl_next.foot = ~ctrl.foot;
        deadline_next  = sat(sum_step);
        if (in_word.sample_index != SIDX_FLYING) begin
          ctrl_next.step_number = ctrl.step_number + 16'd1;
        end
        if (ref_given) begin
          ctrl_next.steps_left = cfg.steps_before_ds;
        end else if (!sl_zero) begin
          ctrl_next.steps_left = sl1 - 8'd1;
        end
        changed = 1'b1;
      end
      if (changed) begin
        ctrl_next.instants = 16'd0;
      end
    end
  end

endmodule
